// File: src/mfp_pkg.sv
// ----------------------------------------------------------------------------
// mfp_pkg: shared types and constants of the monochrome frame buffer plotter
// Transaction payload types, operation codes and rotation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mfp_pkg;

   // Fixed field widths of the request and response transactions.
   localparam int unsigned PosWidth  = 10;
   localparam int unsigned ColWidth  = 7;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned BitWidth  = 3;
   localparam int unsigned RotWidth  = 2;

   // Operation codes of the func field.
   localparam logic FUNC_PLOT = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Rotation register codes.
   localparam logic [RotWidth-1:0] ROT_0   = 2'd0;
   localparam logic [RotWidth-1:0] ROT_90  = 2'd1;
   localparam logic [RotWidth-1:0] ROT_180 = 2'd2;
   localparam logic [RotWidth-1:0] ROT_270 = 2'd3;

   // Mask of the leftmost pixel in a stored byte.
   localparam logic [ByteWidth-1:0] LeftBit = 8'h80;

   // Value of every stored byte after reset (all pixels white).
   localparam logic [ByteWidth-1:0] WhiteByte = 8'hFF;

   typedef struct packed {
      logic                func;
      logic [PosWidth-1:0] x_pos;
      logic [PosWidth-1:0] y_pos;
      logic                pixel_color;
      logic [ColWidth-1:0] read_col;
      logic [PosWidth-1:0] read_row;
   } req_type;

   typedef struct packed {
      logic [ByteWidth-1:0] read_byte;
      logic                 rejected;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/mfp_req_if.sv
// ----------------------------------------------------------------------------
// mfp_req_if: request channel of the frame buffer plotter
// Valid/ready channel that carries one plot or read transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfp_req_if;
   logic             valid;
   logic             ready;
   mfp_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/mfp_rsp_if.sv
// ----------------------------------------------------------------------------
// mfp_rsp_if: response channel of the frame buffer plotter
// Valid/ready channel that carries one result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfp_rsp_if;
   logic             valid;
   logic             ready;
   mfp_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/mfp_ram.sv
// ----------------------------------------------------------------------------
// mfp_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mfp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 5000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: src/mono_framebuffer_pixel_plotter.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_pixel_plotter: one-bit-per-pixel frame store with plotting
//
// A request transaction either plots one pixel (func = plot) or reads one
// stored byte (func = read). A plot is mapped through the rotation register,
// bounds checked, and its bit is set or cleared by read-modify-write of one
// byte. A read returns the byte at (read_col, read_row), MSB leftmost. Every
// request yields exactly one response transaction; an out-of-range request
// sets rejected, returns a zero byte and leaves the store untouched.
//
// A taken request passes through S_MAP, where the single memory is read, and
// S_DONE, where the byte is written back and the response is loaded for output;
// only one request is in flight at a time, and the next is taken back in S_IDLE.
// A new request is taken while an older response still waits in the output
// register. If the receiver stalls, the finished response is parked in a
// holding register and no new request is taken until the output register drains.
//
// Reset: the rotation register returns to zero and a clearing pass writes
// 0xFF to every byte of the store, one byte per cycle (ROW_BYTES times
// PANEL_HEIGHT bytes, 5000 at the default size). No request is taken during
// that pass; rotation writes on the csr port are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_framebuffer_pixel_plotter #(
   parameter int unsigned PANEL_WIDTH  = 200,
   parameter int unsigned PANEL_HEIGHT = 200
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   mfp_req_if.sink                           req_chan,
   mfp_rsp_if.source                         rsp_chan,
   input  wire logic                         csr_wr_en,
   input  wire logic [mfp_pkg::RotWidth-1:0] csr_wr_data
);

   // Store geometry.
   localparam int unsigned RowBytes   = (PANEL_WIDTH + 7) / 8;
   localparam int unsigned StoreBytes = RowBytes * PANEL_HEIGHT;
   localparam int unsigned AddrWidth  = $clog2(StoreBytes);
   localparam int unsigned PW         = mfp_pkg::PosWidth;
   localparam int unsigned CW         = mfp_pkg::ColWidth;
   localparam int unsigned BW         = mfp_pkg::ByteWidth;

   // Bounds and mirror constants; one extra bit holds the value 1024.
   localparam logic [PW:0]   WidthLim  = (PW+1)'(PANEL_WIDTH);
   localparam logic [PW:0]   HeightLim = (PW+1)'(PANEL_HEIGHT);
   localparam logic [PW-1:0] WidthM1   = PW'(PANEL_WIDTH - 1);
   localparam logic [PW-1:0] HeightM1  = PW'(PANEL_HEIGHT - 1);
   localparam logic [CW:0]   RowBytesLim = (CW+1)'(RowBytes);
   localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(StoreBytes - 1);

   // Sequencer states.
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MAP   = 3'd2;
   localparam logic [2:0] S_DONE  = 3'd3;
   localparam logic [2:0] S_HOLD  = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [mfp_pkg::RotWidth-1:0]   rot_ff, rot_in;
   logic [AddrWidth-1:0]           clr_ff, clr_in;

   // Request held for the duration of the read-modify-write.
   logic                           op_ff, op_in;
   logic                           ok_ff, ok_in;
   logic                           color_ff, color_in;
   logic [PW-1:0]                  row_ff, row_in;
   logic [CW-1:0]                  bcol_ff, bcol_in;
   logic [mfp_pkg::BitWidth-1:0]   bit_ff, bit_in;
   logic [AddrWidth-1:0]           addr_ff, addr_in;

   // Output register and the holding register behind it.
   logic                           rsp_valid_ff, rsp_valid_in;
   mfp_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   mfp_pkg::rsp_type               hold_ff, hold_in;

   // Memory ports.
   logic                           mem_wr_en;
   logic [AddrWidth-1:0]           mem_wr_addr;
   logic [BW-1:0]                  mem_wr_data;
   logic                           mem_rd_en;
   logic [BW-1:0]                  mem_rd_data;

   // Combinational helpers.
   mfp_pkg::req_type               req;
   logic                           req_take;
   logic                           out_free;
   logic                           out_load;
   logic [PW-1:0]                  px, py;
   logic                           plot_ok, read_ok;
   logic [BW-1:0]                  pix_mask;
   logic [BW-1:0]                  mod_byte;
   mfp_pkg::rsp_type               result;

   mfp_ram #(
      .WIDTH (BW),
      .DEPTH (StoreBytes)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (addr_in),
      .rd_data (mem_rd_data)
   );

   assign req             = req_chan.data;
   assign req_chan.ready  = (state_ff == S_IDLE);
   assign req_take        = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.data   = rsp_data_ff;
   assign out_free        = !rsp_valid_ff || rsp_chan.ready;

   // Rotation mapping. The logical position is checked against the panel
   // first; a quarter turn additionally needs both coordinates to fit the
   // other axis, otherwise the mirrored coordinate would fall off the panel.
   always_comb begin
      px = req.x_pos;
      py = req.y_pos;
      case (rot_ff)
         mfp_pkg::ROT_0: begin
            px = req.x_pos;
            py = req.y_pos;
         end
         mfp_pkg::ROT_90: begin
            px = WidthM1 - req.y_pos;
            py = req.x_pos;
         end
         mfp_pkg::ROT_180: begin
            px = WidthM1 - req.x_pos;
            py = HeightM1 - req.y_pos;
         end
         mfp_pkg::ROT_270: begin
            px = req.y_pos;
            py = HeightM1 - req.x_pos;
         end
         default: begin
            px = req.x_pos;
            py = req.y_pos;
         end
      endcase
   end

   assign plot_ok = ({1'b0, req.x_pos} < WidthLim) && ({1'b0, req.y_pos} < HeightLim)
                    && (!rot_ff[0]
                        || (({1'b0, req.x_pos} < HeightLim)
                            && ({1'b0, req.y_pos} < WidthLim)));
   assign read_ok = ({1'b0, req.read_col} < RowBytesLim)
                    && ({1'b0, req.read_row} < HeightLim);

   // Modify step on the byte that came back from the store.
   assign pix_mask = mfp_pkg::LeftBit >> bit_ff;
   assign mod_byte = color_ff ? (mem_rd_data | pix_mask) : (mem_rd_data & ~pix_mask);

   always_comb begin
      result.rejected  = !ok_ff;
      result.read_byte = (op_ff == mfp_pkg::FUNC_READ && ok_ff) ? mem_rd_data : '0;
   end

   always_comb begin
      state_in  = state_ff;
      rot_in    = csr_wr_en ? csr_wr_data : rot_ff;
      clr_in    = clr_ff;
      op_in     = op_ff;
      ok_in     = ok_ff;
      color_in  = color_ff;
      row_in    = row_ff;
      bcol_in   = bcol_ff;
      bit_in    = bit_ff;
      hold_in   = hold_ff;
      out_load  = 1'b0;
      rsp_data_in = rsp_data_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = mod_byte;
      mem_rd_en   = 1'b0;

      // Byte address of the held request: row times row length plus column.
      addr_in = AddrWidth'(row_ff) * AddrWidth'(RowBytes) + AddrWidth'(bcol_ff);

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = mfp_pkg::WhiteByte;
            clr_in      = clr_ff + AddrWidth'(1);
            if (clr_ff == LastAddr) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               op_in    = req.func;
               color_in = req.pixel_color;
               if (req.func == mfp_pkg::FUNC_PLOT) begin
                  ok_in   = plot_ok;
                  row_in  = py;
                  bcol_in = px[PW-1:mfp_pkg::BitWidth];
                  bit_in  = px[mfp_pkg::BitWidth-1:0];
               end else begin
                  ok_in   = read_ok;
                  row_in  = req.read_row;
                  bcol_in = req.read_col;
                  bit_in  = '0;
               end
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            mem_rd_en = ok_ff;
            state_in  = S_DONE;
         end
         S_DONE: begin
            mem_wr_en = (op_ff == mfp_pkg::FUNC_PLOT) && ok_ff;
            if (out_free) begin
               out_load    = 1'b1;
               rsp_data_in = result;
               state_in    = S_IDLE;
            end else begin
               hold_in  = result;
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_data_in = hold_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rot_ff       <= mfp_pkg::ROT_0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ok_ff       <= ok_in;
      color_ff    <= color_in;
      row_ff      <= row_in;
      bcol_ff     <= bcol_in;
      bit_ff      <= bit_in;
      addr_ff     <= addr_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   // An accepted request always moves on to the address stage.
   a_take_to_map: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_MAP)
      else $error("accepted request did not enter the address stage");

   // A write-back of pixel data only follows a read issued in the cycle before.
   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && state_ff != S_CLEAR) |-> $past(state_ff) == S_MAP && $past(mem_rd_en))
      else $error("write-back without a preceding read");

   // A rejected response never carries store data.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.rejected) |-> rsp_data_ff.read_byte == '0)
      else $error("rejected response carries a nonzero byte");

   // A waiting response is never overwritten before it is taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> $stable(rsp_data_ff))
      else $error("pending response was overwritten");

endmodule

`default_nettype wire

// File: sim/tb_mono_framebuffer_pixel_plotter.sv
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_pixel_plotter: regression bench for the 1bpp plotter
// Drives plot and read transactions through the valid/ready channels, keeps
// a shadow copy of the frame store and the rotation register, and checks every
// response field by field, in order of arrival, against the shadow copy or a hand-typed response.
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_pixel_plotter;

   timeunit 1ns;
   timeprecision 1ps;

   // Panel geometry. It matches the default parameters of the block.
   localparam int PanelWidth  = 200;
   localparam int PanelHeight = 200;
   localparam int RowBytes    = (PanelWidth + 7) / 8;
   localparam int StoreBytes  = RowBytes * PanelHeight;

   // Run shape. The watchdog limit covers the clearing pass after reset
   // (one cycle per stored byte) plus the long receiver hold-off, several times over.
   localparam int RandomItems   = 500;
   localparam int PhaseItems    = 100;
   localparam int QuietTail     = 80;
   localparam int LongHold      = 300;
   localparam int HoldAfter     = 150;
   localparam int DrainCycles   = 10;
   localparam int WatchdogLimit = 20000;
   localparam int MaxReports    = 30;

   // One row of the directed stimulus. When typed is set, want holds the
   // response written out by hand; otherwise the shadow model decides.
   typedef struct packed {
      logic [mfp_pkg::RotWidth-1:0] rot;
      mfp_pkg::req_type             req;
      logic                         typed;
      mfp_pkg::rsp_type             want;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [mfp_pkg::RotWidth-1:0] csr_wr_data;

   mfp_req_if req_chan ();
   mfp_rsp_if rsp_chan ();

   mono_framebuffer_pixel_plotter #(
      .PANEL_WIDTH  (PanelWidth),
      .PANEL_HEIGHT (PanelHeight)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow state: the frame store as the block should hold it, and the
   // rotation that was last written.
   logic [mfp_pkg::ByteWidth-1:0] frame_copy [StoreBytes];
   logic [mfp_pkg::RotWidth-1:0]  rotation_copy;

   // Responses still owed by the block, oldest first.
   mfp_pkg::rsp_type pending_results [$];

   int mismatch_count;
   int requests_taken;
   int idle_cycles;
   bit idling_on;

   // Byte that the last in-range plot touched. Reads aim here often so that
   // they return bytes with cleared bits rather than plain white.
   int hot_col;
   int hot_row;

   directed_row_type directed_rows [$];

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one accepted transaction to the shadow store and returns the
   // response that the block owes for it.
   function automatic mfp_pkg::rsp_type apply_to_frame(input mfp_pkg::req_type r);
      mfp_pkg::rsp_type res;
      int xi;
      int yi;
      int px;
      int py;
      int addr;
      logic [mfp_pkg::ByteWidth-1:0] mask;
      res = '0;
      if (r.func == mfp_pkg::FUNC_PLOT) begin
         xi = int'(r.x_pos);
         yi = int'(r.y_pos);
         // The logical position is checked before rotation, whatever the
         // rotation is.
         if (xi >= PanelWidth || yi >= PanelHeight) begin
            res.rejected = 1'b1;
         end else begin
            case (rotation_copy)
               mfp_pkg::ROT_90: begin
                  px = PanelWidth - 1 - yi;
                  py = xi;
               end
               mfp_pkg::ROT_180: begin
                  px = PanelWidth - 1 - xi;
                  py = PanelHeight - 1 - yi;
               end
               mfp_pkg::ROT_270: begin
                  px = yi;
                  py = PanelHeight - 1 - xi;
               end
               default: begin
                  px = xi;
                  py = yi;
               end
            endcase
            // The mapped position is checked as well; on a non-square panel
            // a rotated plot can fall outside.
            if (px < 0 || py < 0 || px >= PanelWidth || py >= PanelHeight) begin
               res.rejected = 1'b1;
            end else begin
               addr = px / 8 + py * RowBytes;
               mask = mfp_pkg::LeftBit >> (px % 8);
               if (r.pixel_color) begin
                  frame_copy[addr] = frame_copy[addr] | mask;
               end else begin
                  frame_copy[addr] = frame_copy[addr] & ~mask;
               end
               hot_col = px / 8;
               hot_row = py;
            end
         end
      end else begin
         if (int'(r.read_col) < RowBytes && int'(r.read_row) < PanelHeight) begin
            res.read_byte = frame_copy[int'(r.read_col) + int'(r.read_row) * RowBytes];
         end else begin
            res.rejected = 1'b1;
         end
      end
      return res;
   endfunction

   // Builds one directed row.
   function automatic directed_row_type stim(input logic [mfp_pkg::RotWidth-1:0] rot,
                                             input logic func, input int x, input int y,
                                             input int color, input int col, input int rowi,
                                             input int typed, input int rd_byte,
                                             input int rej);
      directed_row_type d;
      d.rot             = rot;
      d.req.func        = func;
      d.req.x_pos       = 10'(x);
      d.req.y_pos       = 10'(y);
      d.req.pixel_color = 1'(color);
      d.req.read_col    = 7'(col);
      d.req.read_row    = 10'(rowi);
      d.typed           = 1'(typed);
      d.want.read_byte  = 8'(rd_byte);
      d.want.rejected   = 1'(rej);
      return d;
   endfunction

   // Random transaction. Every field starts fully random, so the fields that
   // an operation ignores still carry noise; most transactions are then
   // shaped into in-range plots and reads, the rest stay as they are and are
   // mostly rejected.
   function automatic mfp_pkg::req_type random_request();
      mfp_pkg::req_type r;
      int pick;
      r.func        = 1'($urandom);
      r.x_pos       = 10'($urandom);
      r.y_pos       = 10'($urandom);
      r.pixel_color = 1'($urandom);
      r.read_col    = 7'($urandom);
      r.read_row    = 10'($urandom);
      pick = int'($urandom_range(0, 99));
      if (pick < 20) begin
         // Plots clustered in a small corner hit the same bytes again and again.
         r.func  = mfp_pkg::FUNC_PLOT;
         r.x_pos = 10'($urandom_range(0, 7));
         r.y_pos = 10'($urandom_range(0, 7));
      end else if (pick < 45) begin
         r.func  = mfp_pkg::FUNC_PLOT;
         r.x_pos = 10'($urandom_range(0, PanelWidth - 1));
         r.y_pos = 10'($urandom_range(0, PanelHeight - 1));
      end else if (pick < 80) begin
         r.func = mfp_pkg::FUNC_READ;
         if ($urandom_range(0, 1) != 0) begin
            r.read_col = 7'(hot_col);
            r.read_row = 10'(hot_row);
         end else begin
            r.read_col = 7'($urandom_range(0, RowBytes - 1));
            r.read_row = 10'($urandom_range(0, PanelHeight - 1));
         end
      end
      return r;
   endfunction

   // Offers one transaction and waits for the handshake. The expected
   // response is queued at the edge that accepts the transaction. Afterwards
   // the sender may go quiet for a short burst.
   task automatic offer(input mfp_pkg::req_type r, input logic typed,
                        input mfp_pkg::rsp_type want);
      mfp_pkg::rsp_type owed;
      req_chan.valid <= 1'b1;
      req_chan.data  <= r;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      owed = apply_to_frame(r);
      if (typed) begin
         owed = want;
      end
      pending_results.push_back(owed);
      requests_taken++;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // The rotation register is only written while the block is idle: the
   // sender stops and every owed response must have come back first. Each
   // transaction produces a response, so an empty queue means an idle block.
   task automatic set_rotation(input logic [mfp_pkg::RotWidth-1:0] rot);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rot;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      rotation_copy = rot;
   endtask

   // Response checker. Each accepted response is matched against the oldest
   // owed one; a response with nothing owed is a failure of its own.
   always @(posedge clock) begin
      mfp_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MaxReports) begin
               $display("%0t: response with none owed, actual byte %h rejected %b",
                        $time, rsp_chan.data.read_byte, rsp_chan.data.rejected);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.data.read_byte !== want.read_byte) begin
               mismatch_count++;
               if (mismatch_count <= MaxReports) begin
                  $display("%0t: read_byte mismatch, expected %h actual %h",
                           $time, want.read_byte, rsp_chan.data.read_byte);
               end
            end
            if (rsp_chan.data.rejected !== want.rejected) begin
               mismatch_count++;
               if (mismatch_count <= MaxReports) begin
                  $display("%0t: rejected mismatch, expected %b actual %b",
                           $time, want.rejected, rsp_chan.data.rejected);
               end
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves a transaction.
   // It is generous enough to cover the clearing pass and the long hold-off.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver. It stalls in short random bursts while idling is on, and once,
   // after enough requests have been taken, it holds off for a long stretch
   // so that the block parks its response, fills up and stops taking requests
   // while the sender keeps offering.
   initial begin
      int stall_left;
      bit long_hold_done;
      stall_left     = 0;
      long_hold_done = 1'b0;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (!long_hold_done && requests_taken >= HoldAfter) begin
            long_hold_done = 1'b1;
            stall_left     = LongHold;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (idling_on && $urandom_range(0, 5) == 0) begin
               stall_left = int'($urandom_range(1, 7));
            end
         end
      end
   end

   // Sender and run control.
   initial begin
      logic [mfp_pkg::RotWidth-1:0] phase_rot [5];
      int phase;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = mfp_pkg::ROT_0;
      reset          = 1'b1;
      clock          = 1'b0;
      mismatch_count = 0;
      requests_taken = 0;
      idle_cycles    = 0;
      idling_on      = 1'b1;
      hot_col        = 0;
      hot_row        = 0;
      rotation_copy  = mfp_pkg::ROT_0;
      foreach (frame_copy[i]) begin
         frame_copy[i] = mfp_pkg::WhiteByte;
      end

      // Directed rows. Responses are typed in where they follow at a glance:
      // the white store after reset, the corner pixels and every rejection.
      //                           rot      func       x     y    c     col  row  typ  byte  rej
      // Reads straight after reset, at both ends of the store and out of it.
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_READ, 0,    0,    0,  0,   0,    1, 'hFF, 0));
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_READ, 0,    0,    0,  24,  199,  1, 'hFF, 0));
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_READ, 0,    0,    0,  25,  0,    1, 0,    1));
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_READ, 0,    0,    0,  127, 1023, 1, 0,    1));
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_READ, 0,    0,    0,  0,   200,  1, 0,    1));
      // Clearing the top-left and bottom-right pixels, read back.
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_PLOT, 0,    0,    0,  0,   0,    1, 0,    0));
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_READ, 0,    0,    0,  0,   0,    1, 'h7F, 0));
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_PLOT, 199,  199,  0,  0,   0,    1, 0,    0));
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_READ, 0,    0,    0,  24,  199,  1, 'hFE, 0));
      // Logical bounds, including the largest field values.
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_PLOT, 200,  0,    1,  0,   0,    1, 0,    1));
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_PLOT, 0,    200,  1,  0,   0,    1, 0,    1));
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_PLOT, 1023, 1023, 1,  127, 1023, 1, 0,    1));
      // Setting a bit back to white.
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_PLOT, 0,    0,    1,  0,   0,    1, 0,    0));
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_READ, 0,    0,    0,  0,   0,    1, 'hFF, 0));
      // Fields of the other operation must be ignored.
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_PLOT, 5,    3,    0,  127, 1023, 0, 0,    0));
      directed_rows.push_back(stim(mfp_pkg::ROT_0,   mfp_pkg::FUNC_READ, 1023, 1023, 1,  0,   3,    0, 0,    0));
      // Corners under each rotation.
      directed_rows.push_back(stim(mfp_pkg::ROT_90,  mfp_pkg::FUNC_PLOT, 0,    0,    0,  0,   0,    0, 0,    0));
      directed_rows.push_back(stim(mfp_pkg::ROT_90,  mfp_pkg::FUNC_READ, 0,    0,    0,  24,  0,    0, 0,    0));
      directed_rows.push_back(stim(mfp_pkg::ROT_90,  mfp_pkg::FUNC_PLOT, 199,  199,  0,  0,   0,    0, 0,    0));
      directed_rows.push_back(stim(mfp_pkg::ROT_90,  mfp_pkg::FUNC_READ, 0,    0,    0,  0,   199,  0, 0,    0));
      directed_rows.push_back(stim(mfp_pkg::ROT_180, mfp_pkg::FUNC_PLOT, 1,    0,    0,  0,   0,    0, 0,    0));
      directed_rows.push_back(stim(mfp_pkg::ROT_180, mfp_pkg::FUNC_READ, 0,    0,    0,  24,  199,  0, 0,    0));
      directed_rows.push_back(stim(mfp_pkg::ROT_180, mfp_pkg::FUNC_PLOT, 200,  0,    0,  0,   0,    1, 0,    1));
      directed_rows.push_back(stim(mfp_pkg::ROT_270, mfp_pkg::FUNC_PLOT, 0,    0,    0,  0,   0,    0, 0,    0));
      directed_rows.push_back(stim(mfp_pkg::ROT_270, mfp_pkg::FUNC_READ, 0,    0,    0,  0,   199,  0, 0,    0));
      directed_rows.push_back(stim(mfp_pkg::ROT_270, mfp_pkg::FUNC_PLOT, 0,    1023, 1,  0,   0,    1, 0,    1));

      // Reset is held once, at the start. The block then runs its clearing
      // pass and takes no request until it is done; the sender just waits on
      // ready.
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].rot != rotation_copy) begin
            set_rotation(directed_rows[i].rot);
         end
         offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end

      // Random part in phases, each under a rotation set at its start; the change at
      // each phase also makes the sender wait until all responses are in.
      // The third phase runs without idling and so does the tail.
      phase_rot[0] = mfp_pkg::ROT_270;
      phase_rot[1] = mfp_pkg::ROT_0;
      phase_rot[2] = mfp_pkg::ROT_90;
      phase_rot[3] = mfp_pkg::ROT_180;
      phase_rot[4] = mfp_pkg::ROT_270;
      for (int i = 0; i < RandomItems; i++) begin
         phase = i / PhaseItems;
         if (i % PhaseItems == 0) begin
            set_rotation(phase_rot[phase % 5]);
         end
         idling_on = (phase != 2) && (i < RandomItems - QuietTail);
         offer(random_request(), 1'b0, '0);
      end
      req_chan.valid <= 1'b0;

      // Let every owed response drain; the watchdog bounds this wait. A few
      // more cycles then catch any response that should not come at all.
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
